// ===== src/bpe_pkg.sv =====
package bpe_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	localparam int SIZE_W = 13;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int LVL_W  = 8;
	localparam int CFG_W  = SIZE_W;
	localparam int IDX_W  = 2;

	localparam logic [LVL_W-1:0] LVL_FULL = 8'd255;

	typedef enum logic [IDX_W-1:0] {
		REG_FORMAT_MODE  = 2'd0,
		REG_MAX_LEVEL    = 2'd1,
		REG_IMAGE_WIDTH  = 2'd2,
		REG_IMAGE_HEIGHT = 2'd3
	} reg_idx_t;

	localparam logic [1:0] MODE_P4 = 2'd0;
	localparam logic [1:0] MODE_P5 = 2'd1;
	localparam logic [1:0] MODE_P6 = 2'd2;

	typedef enum logic [1:0] {
		FMT_BITMAP,
		FMT_GRAY,
		FMT_COLOR
	} fmt_t;

	typedef struct packed {
		logic [LVL_W-1:0] blue_level;
		logic [LVL_W-1:0] green_level;
		logic [LVL_W-1:0] red_level;
	} pixel_t;

	typedef struct packed {
		logic [LVL_W-1:0] out_byte;
		logic             frame_last;
	} raster_t;

	// per-pixel control that rides along with the lanes
	typedef struct packed {
		logic [1:0]       count;
		logic             frame_end;
		fmt_t             fmt;
		logic [LVL_W-1:0] pack_byte;
	} ctl_t;

endpackage

// ===== src/bpe_pack.sv =====
module bpe_pack (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [bpe_pkg::LVL_W-1:0]     blue_level,
	input  bpe_pkg::fmt_t                 fmt,
	input  logic [bpe_pkg::SIZE_W-1:0]    image_width,
	input  logic [bpe_pkg::SIZE_W-1:0]    image_height,
	output bpe_pkg::ctl_t                 ctl
);
	import bpe_pkg::*;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [7:0]       bits_q;
	logic [2:0]       fill_q;

	logic [COL_W-1:0] col_last;
	logic [ROW_W-1:0] row_last;
	logic             row_end;
	logic             frame_end;
	logic [7:0]       bits_n;
	logic [3:0]       fill_n;
	logic [3:0]       sh;
	logic             flush;

	// last column / row index after clamping the size to 1..max
	always_comb begin
		if (image_width == '0) begin
			col_last = '0;
		end else if (image_width > SIZE_W'(MAX_WIDTH)) begin
			col_last = COL_W'(MAX_WIDTH - 1);
		end else begin
			col_last = COL_W'(image_width - SIZE_W'(1));
		end
		if (image_height == '0) begin
			row_last = '0;
		end else if (image_height > SIZE_W'(MAX_HEIGHT)) begin
			row_last = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			row_last = ROW_W'(image_height - SIZE_W'(1));
		end
	end

	assign row_end   = col_q >= col_last;
	assign frame_end = row_end && (row_q >= row_last);

	assign bits_n = {bits_q[6:0], (blue_level != LVL_FULL)};
	assign fill_n = {1'b0, fill_q} + 4'd1;
	assign sh     = 4'd8 - fill_n;
	assign flush  = (fill_n == 4'd8) || row_end;

	always_comb begin
		ctl.frame_end = frame_end;
		ctl.fmt       = fmt;
		ctl.pack_byte = bits_n << sh[2:0];
		unique case (fmt)
			FMT_BITMAP: ctl.count = flush ? 2'd1 : 2'd0;
			FMT_GRAY:   ctl.count = 2'd1;
			FMT_COLOR:  ctl.count = 2'd3;
			default:    ctl.count = 2'd3;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			bits_q <= '0;
			fill_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q  <= '0;
				row_q  <= frame_end ? '0 : row_q + ROW_W'(1);
				bits_q <= '0;
				fill_q <= '0;
			end else begin
				col_q <= col_q + COL_W'(1);
				if (fmt == FMT_BITMAP) begin
					if (flush) begin
						bits_q <= '0;
						fill_q <= '0;
					end else begin
						bits_q <= bits_n;
						fill_q <= fill_n[2:0];
					end
				end
			end
		end
	end

endmodule

// ===== src/bpe_scale_lane.sv =====
module bpe_scale_lane (
	input  logic                      clk,
	input  logic                      en_s1,
	input  logic                      en_s2,
	input  logic [bpe_pkg::LVL_W-1:0] level,
	input  logic [bpe_pkg::LVL_W-1:0] max_level,
	output logic [bpe_pkg::LVL_W-1:0] scaled
);
	import bpe_pkg::*;

	logic [2*LVL_W-1:0] prod_s1;
	logic [2*LVL_W-1:0] sum;
	logic [LVL_W-1:0]   lvl_s2;

	// floor(p/255) for p <= 255*255, every level*max_level product: (p + 1 + (p >> 8)) >> 8
	assign sum = prod_s1 + (2*LVL_W)'(1) + (prod_s1 >> LVL_W);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_s1 <= level * max_level;
		end
		if (en_s2) begin
			lvl_s2 <= sum[2*LVL_W-1:LVL_W];
		end
	end

	assign scaled = lvl_s2;

endmodule

// ===== src/bpe_merge.sv =====
module bpe_merge (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load_valid,
	input  bpe_pkg::ctl_t             ctl,
	input  logic [bpe_pkg::LVL_W-1:0] red_scaled,
	input  logic [bpe_pkg::LVL_W-1:0] green_scaled,
	input  logic [bpe_pkg::LVL_W-1:0] blue_scaled,
	output logic                      take,
	output bpe_pkg::raster_t          raster,
	output logic                      raster_valid,
	input  logic                      raster_ready
);
	import bpe_pkg::*;

	logic [1:0]       cnt_q;
	logic             last_q;
	logic [LVL_W-1:0] data_q [3];
	logic [LVL_W-1:0] first;
	logic             xfer;

	always_comb begin
		unique case (ctl.fmt)
			FMT_BITMAP: first = ctl.pack_byte;
			FMT_GRAY:   first = blue_scaled;
			FMT_COLOR:  first = red_scaled;
			default:    first = red_scaled;
		endcase
	end

	assign xfer = raster_valid && raster_ready;
	// room for the next pixel once the final byte leaves
	assign take = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && raster_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= 1'b0;
		end else if (take) begin
			cnt_q  <= load_valid ? ctl.count : 2'd0;
			last_q <= ctl.frame_end;
		end else if (xfer) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_q[0] <= first;
			data_q[1] <= green_scaled;
			data_q[2] <= blue_scaled;
		end else if (xfer) begin
			data_q[0] <= data_q[1];
			data_q[1] <= data_q[2];
		end
	end

	assign raster_valid      = cnt_q != 2'd0;
	assign raster.out_byte   = data_q[0];
	assign raster.frame_last = last_q && (cnt_q == 2'd1);

endmodule

// ===== src/binary_pnm_pixel_encoder.sv =====
// A pixel passes the multiply, /255 and output registers to reach its first raster byte.
// Throughput: P6 takes a pixel only as the prior pixel's third byte leaves the output;
//   P5 and P4 one pixel per cycle unless stalled (P4: a byte every 8 pixels or at row end).
// Three scaling lanes (R, G, B) run in parallel; the merge stage serializes their bytes.
// Reset (arst_n low, async): counters, packing state and pipeline valids clear,
//   registers return to P6, max level 255, 1x1 frame.
module binary_pnm_pixel_encoder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [bpe_pkg::IDX_W-1:0] cfg_index,
	input  logic [bpe_pkg::CFG_W-1:0] cfg_data,
	input  bpe_pkg::pixel_t           pixel,
	input  logic                      pixel_valid,
	output logic                      pixel_ready,
	output bpe_pkg::raster_t          raster,
	output logic                      raster_valid,
	input  logic                      raster_ready
);
	import bpe_pkg::*;

	logic [1:0]        format_mode_q;
	logic [LVL_W-1:0]  max_level_q;
	logic [SIZE_W-1:0] image_width_q;
	logic [SIZE_W-1:0] image_height_q;

	fmt_t              fmt;
	ctl_t              ctl_in;
	ctl_t              ctl_s1;
	ctl_t              ctl_s2;
	logic              v_s1;
	logic              v_s2;
	logic              ready_s1;
	logic              ready_s2;
	logic              take;
	logic              accept;
	logic [LVL_W-1:0]  red_scaled;
	logic [LVL_W-1:0]  green_scaled;
	logic [LVL_W-1:0]  blue_scaled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_mode_q  <= MODE_P6;
			max_level_q    <= LVL_FULL;
			image_width_q  <= SIZE_W'(1);
			image_height_q <= SIZE_W'(1);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FORMAT_MODE:  format_mode_q  <= cfg_data[1:0];
				REG_MAX_LEVEL:    max_level_q    <= cfg_data[LVL_W-1:0];
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[SIZE_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// unused mode code behaves as color
	always_comb begin
		unique case (format_mode_q)
			MODE_P4: fmt = FMT_BITMAP;
			MODE_P5: fmt = FMT_GRAY;
			MODE_P6: fmt = FMT_COLOR;
			default: fmt = FMT_COLOR;
		endcase
	end

	assign ready_s2    = !v_s2 || take;
	assign ready_s1    = !v_s1 || ready_s2;
	assign pixel_ready = ready_s1;
	assign accept      = pixel_valid && pixel_ready;

	bpe_pack u_pack (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.blue_level   (pixel.blue_level),
		.fmt          (fmt),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.ctl          (ctl_in)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= accept;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			ctl_s1 <= ctl_in;
		end
		if (ready_s2) begin
			ctl_s2 <= ctl_s1;
		end
	end

	bpe_scale_lane u_lane_red (
		.clk       (clk),
		.en_s1     (ready_s1),
		.en_s2     (ready_s2),
		.level     (pixel.red_level),
		.max_level (max_level_q),
		.scaled    (red_scaled)
	);

	bpe_scale_lane u_lane_green (
		.clk       (clk),
		.en_s1     (ready_s1),
		.en_s2     (ready_s2),
		.level     (pixel.green_level),
		.max_level (max_level_q),
		.scaled    (green_scaled)
	);

	bpe_scale_lane u_lane_blue (
		.clk       (clk),
		.en_s1     (ready_s1),
		.en_s2     (ready_s2),
		.level     (pixel.blue_level),
		.max_level (max_level_q),
		.scaled    (blue_scaled)
	);

	bpe_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (v_s2),
		.ctl          (ctl_s2),
		.red_scaled   (red_scaled),
		.green_scaled (green_scaled),
		.blue_scaled  (blue_scaled),
		.take         (take),
		.raster       (raster),
		.raster_valid (raster_valid),
		.raster_ready (raster_ready)
	);

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !ready_s1 |=> v_s1 && $stable(ctl_s1))
		else $error("stage 1 lost or changed a stalled pixel");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !ready_s2 |=> v_s2 && $stable(ctl_s2))
		else $error("stage 2 lost or changed a stalled pixel");

	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("transferred pixel did not enter stage 1");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> pixel_ready)
		else $error("input stalled with empty pipeline");

endmodule

// ===== dv/binary_pnm_pixel_encoder_tb.sv =====
module binary_pnm_pixel_encoder_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bpe_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = REG_FORMAT_MODE;
	logic [CFG_W-1:0] cfg_data = '0;
	pixel_t pixel = '0;
	logic pixel_valid = 1'b0;
	logic pixel_ready;
	raster_t raster;
	logic raster_valid;
	logic raster_ready = 1'b0;

	pixel_t pending_pixels[$];
	raster_t raster_due[$];
	logic pixel_xfer = 1'b0;
	logic calm = 1'b0;
	logic hold_request = 1'b0;
	int hold_left = 0;
	int errors = 0;

	// shadow of the encoder registers and position/packing state
	logic [1:0] cur_mode = MODE_P6;
	logic [7:0] cur_max = LVL_FULL;
	logic [12:0] cur_width = 13'd1;
	logic [12:0] cur_height = 13'd1;
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;
	int unsigned bit_count = 0;
	logic [7:0] bit_acc = '0;

	binary_pnm_pixel_encoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel(pixel),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.raster(raster),
		.raster_valid(raster_valid),
		.raster_ready(raster_ready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned fit_size(input logic [12:0] v, input int unsigned top);
		if (v == 0)
			return 1;
		if (v > top)
			return top;
		return 32'(v);
	endfunction

	function automatic logic [7:0] scale_sample(input logic [7:0] v);
		logic [15:0] prod;
		prod = v * cur_max;
		return 8'(prod / 16'd255);
	endfunction

	function automatic void encode_pixel(input pixel_t px);
		int unsigned w;
		int unsigned h;
		logic row_end;
		logic frame_end;
		w = fit_size(cur_width, MAX_WIDTH);
		h = fit_size(cur_height, MAX_HEIGHT);
		// >= so a size lowered under the current position still ends the row
		row_end = col_pos >= w - 1;
		frame_end = row_end && row_pos >= h - 1;
		if (cur_mode == MODE_P4) begin
			bit_acc = {bit_acc[6:0], px.blue_level != LVL_FULL};
			bit_count++;
			if (bit_count >= 8 || row_end) begin
				raster_due.push_back({8'(bit_acc << (8 - bit_count)), frame_end});
				bit_acc = '0;
				bit_count = 0;
			end
		end else if (cur_mode == MODE_P5) begin
			raster_due.push_back({scale_sample(px.blue_level), frame_end});
		end else begin
			raster_due.push_back({scale_sample(px.red_level), 1'b0});
			raster_due.push_back({scale_sample(px.green_level), 1'b0});
			raster_due.push_back({scale_sample(px.blue_level), frame_end});
		end
		if (row_end) begin
			// leftover bits are lost at row end outside bitmap mode
			bit_acc = '0;
			bit_count = 0;
			col_pos = 0;
			row_pos = frame_end ? 0 : row_pos + 1;
		end else
			col_pos++;
	endfunction

	// sender
	always @(negedge clk) begin
		if (arst_n && (!pixel_valid || pixel_xfer)) begin
			if (pending_pixels.size() != 0 && (calm || $urandom_range(99) >= 18)) begin
				pixel <= pending_pixels.pop_front();
				pixel_valid <= 1'b1;
			end else
				pixel_valid <= 1'b0;
		end
	end

	// receiver, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			raster_ready <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left <= HOLD_CYCLES;
			raster_ready <= 1'b0;
		end else
			raster_ready <= calm || $urandom_range(99) >= 18;
	end

	always @(posedge clk) begin : monitor
		raster_t got;
		raster_t want;
		pixel_xfer = arst_n && pixel_valid && pixel_ready;
		if (pixel_xfer)
			encode_pixel(pixel);
		if (arst_n && raster_valid && raster_ready) begin
			got = raster;
			if (raster_due.size() == 0) begin
				$display("%0t: raster transfer with none pending, got byte %02h last %0b",
					$time, got.out_byte, got.frame_last);
				errors++;
			end else begin
				want = raster_due.pop_front();
				if (got.out_byte !== want.out_byte) begin
					$display("%0t: out_byte expected %02h got %02h",
						$time, want.out_byte, got.out_byte);
					errors++;
				end
				if (got.frame_last !== want.frame_last) begin
					$display("%0t: frame_last expected %0b got %0b",
						$time, want.frame_last, got.frame_last);
					errors++;
				end
			end
		end
	end

	task automatic drain();
		while (pending_pixels.size() != 0 || pixel_valid || raster_due.size() != 0)
			@(posedge clk);
		// a bitmap pixel may still be in flight without a byte behind it
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FORMAT_MODE: cur_mode = val[1:0];
			REG_MAX_LEVEL: cur_max = val[7:0];
			REG_IMAGE_WIDTH: cur_width = val;
			REG_IMAGE_HEIGHT: cur_height = val;
		endcase
	endtask

	task automatic set_format(input logic [1:0] mode, input logic [7:0] lvl,
		input logic [12:0] w, input logic [12:0] h);
		drain();
		write_reg(REG_FORMAT_MODE, CFG_W'(mode));
		write_reg(REG_MAX_LEVEL, CFG_W'(lvl));
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
	endtask

	initial begin : stimulus
		int pick;
		int n_items;
		int phase;
		int sent;
		logic [1:0] mode;
		logic [7:0] lvl;
		logic [7:0] blue;
		logic [12:0] w;
		logic [12:0] h;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: color, full scale, 1x1 frame
		pending_pixels.push_back({8'd0, 8'd0, 8'd0});
		pending_pixels.push_back({8'd255, 8'd255, 8'd255});

		// zero scale, zero sizes behave as 1
		set_format(MODE_P5, 8'd0, 13'd0, 13'd0);
		pending_pixels.push_back({8'd255, 8'd17, 8'd34});
		pending_pixels.push_back({8'd128, 8'd0, 8'd0});

		// bitmap row of 10: one full byte, then two bits padded
		set_format(MODE_P4, 8'd200, 13'd10, 13'd1);
		for (int i = 0; i < 10; i++) begin
			blue = (i % 3 == 0) ? 8'd255 : (i % 3 == 1) ? 8'd254 : 8'd0;
			pending_pixels.push_back({blue, 8'($urandom), 8'($urandom)});
		end

		// width lowered below the current column
		set_format(MODE_P5, 8'd77, 13'd6, 13'd3);
		for (int i = 0; i < 3; i++)
			pending_pixels.push_back({8'($urandom), 8'($urandom), 8'($urandom)});
		drain();
		write_reg(REG_IMAGE_WIDTH, 13'd2);
		pending_pixels.push_back({8'd200, 8'd1, 8'd2});

		// partial bitmap byte dropped by a gray row end, then a fresh bit left pending
		set_format(MODE_P4, LVL_FULL, 13'd4, 13'd1);
		pending_pixels.push_back({8'd0, 8'd0, 8'd0});
		pending_pixels.push_back({8'd0, 8'd0, 8'd0});
		drain();
		write_reg(REG_FORMAT_MODE, CFG_W'(MODE_P5));
		pending_pixels.push_back({8'd9, 8'd0, 8'd0});
		pending_pixels.push_back({8'd250, 8'd0, 8'd0});
		drain();
		write_reg(REG_FORMAT_MODE, CFG_W'(MODE_P4));
		pending_pixels.push_back({8'd1, 8'd0, 8'd0});

		// spare mode code acts as color; oversize frame clamps
		set_format(MODE_SPARE, 8'd1, 13'h1fff, 13'h1fff);
		pending_pixels.push_back({8'd255, 8'd254, 8'd128});
		pending_pixels.push_back({8'd127, 8'd0, 8'd255});

		phase = 0;
		sent = 0;
		while (sent < 480) begin
			pick = $urandom_range(9);
			mode = pick < 3 ? MODE_P4 : pick < 6 ? MODE_P5 : pick < 9 ? MODE_P6 : MODE_SPARE;
			pick = $urandom_range(9);
			lvl = pick == 0 ? 8'd0 : pick == 1 ? 8'd1 : pick == 2 ? LVL_FULL :
				8'($urandom_range(255));
			pick = $urandom_range(19);
			w = pick == 0 ? 13'd0 : pick == 1 ? 13'(MAX_WIDTH) : pick == 2 ? 13'h1fff :
				13'($urandom_range(1, 24));
			pick = $urandom_range(19);
			h = pick == 0 ? 13'd0 : pick == 1 ? 13'(MAX_HEIGHT) : pick == 2 ? 13'h1fff :
				13'($urandom_range(1, 5));
			n_items = $urandom_range(12, 40);
			if (phase == 2)
				n_items = 80;
			if (phase == 4) begin
				mode = MODE_P6;
				n_items = 60;
			end
			set_format(mode, lvl, w, h);
			calm = (phase == 2);
			for (int i = 0; i < n_items; i++) begin
				blue = ($urandom_range(3) == 0) ? LVL_FULL : 8'($urandom);
				pending_pixels.push_back({blue, 8'($urandom), 8'($urandom)});
			end
			// stall the output while the sender keeps offering color pixels
			if (phase == 4)
				hold_request = 1'b1;
			sent += n_items;
			phase++;
		end
		drain();

		if (errors == 0)
			$display("binary_pnm_pixel_encoder verification clean");
		else
			$display("binary_pnm_pixel_encoder verification failed");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("binary_pnm_pixel_encoder verification failed");
		$finish;
	end

endmodule
